@@ hw/rtl/b32cd_pkg.sv @@
// Package for the Crockford base32 decoder: status codes, character classes,
// the character classifier and default constants. No dependencies.

package b32cd_pkg;

    // Default limit on scanned characters per string
    localparam int unsigned MAX_INPUT_DEFAULT = 4096;

    // Register widths and reset values
    localparam int unsigned CFG_W            = 13;
    localparam logic [12:0] CAPACITY_RESET   = 13'd4096;
    localparam logic [12:0] EXPECTED_RESET   = 13'd0;

    // Register indexes
    typedef enum logic {
        REG_OUTPUT_CAPACITY = 1'b0,
        REG_EXPECTED_BYTES  = 1'b1
    } reg_index_t;

    // End-of-string status codes
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_CAP_BELOW_EXP = 3'd1,
        ST_TOO_LONG      = 3'd2,
        ST_BAD_CHAR      = 3'd3,
        ST_OUTPUT_FULL   = 3'd4,
        ST_NONZERO_PAD   = 3'd5,
        ST_CHAR_COUNT    = 3'd6,
        ST_BYTE_COUNT    = 3'd7
    } status_t;

    // Characters of note
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'd32;

    // Class of one character: skipped, bad, or a 5-bit value
    typedef struct packed {
        logic       skip;
        logic       bad;
        logic [4:0] value;
    } cls_t;

    // Crockford letter table, A at index 0; U is bad, I/L alias 1, O aliases 0
    function automatic cls_t letter_class(input logic [4:0] idx);
        cls_t r;
        r.skip  = 1'b0;
        r.bad   = 1'b0;
        r.value = 5'd0;
        case (idx)
            5'd0:  r.value = 5'd10;
            5'd1:  r.value = 5'd11;
            5'd2:  r.value = 5'd12;
            5'd3:  r.value = 5'd13;
            5'd4:  r.value = 5'd14;
            5'd5:  r.value = 5'd15;
            5'd6:  r.value = 5'd16;
            5'd7:  r.value = 5'd17;
            5'd8:  r.value = 5'd1;
            5'd9:  r.value = 5'd18;
            5'd10: r.value = 5'd19;
            5'd11: r.value = 5'd1;
            5'd12: r.value = 5'd20;
            5'd13: r.value = 5'd21;
            5'd14: r.value = 5'd0;
            5'd15: r.value = 5'd22;
            5'd16: r.value = 5'd23;
            5'd17: r.value = 5'd24;
            5'd18: r.value = 5'd25;
            5'd19: r.value = 5'd26;
            5'd21: r.value = 5'd27;
            5'd22: r.value = 5'd28;
            5'd23: r.value = 5'd29;
            5'd24: r.value = 5'd30;
            5'd25: r.value = 5'd31;
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

    // Classify one character (the result is unused for the terminator)
    function automatic cls_t classify(input logic [7:0] c);
        cls_t       r;
        logic [7:0] u;
        r.skip  = 1'b0;
        r.bad   = 1'b0;
        r.value = 5'd0;
        u = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ? (c - CASE_DIFF) : c;
        if ((c == CHAR_DASH) || (c == CHAR_SPACE) || (c == CHAR_TAB) ||
            (c == CHAR_CR) || (c == CHAR_LF)) begin
            r.skip = 1'b1;
        end else if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            r.value = 5'(c - CHAR_ZERO);
        end else if ((u >= CHAR_UC_A) && (u <= CHAR_UC_Z)) begin
            r = letter_class(5'(u - CHAR_UC_A));
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/base32_crockford_decoder_top.sv @@
// Crockford base32 decoder, top level: input stage, decode state, result register.
// Depends on b32cd_pkg.
//
// Usage:
//   s_valid/s_ready/s_text_char carry one character per transfer; a zero
//   character ends the string. m_valid/m_ready carry results: a data byte
//   (m_is_final low) or the end-of-string status (m_is_final high) with the
//   byte count for the string. Skipped, bad and ignored characters give no
//   result. The cfg_* port writes output_capacity (index 0) and
//   expected_bytes (index 1) at any edge with cfg_wr_en high; write only
//   while no string characters are in flight.
//   A taken character is held in the input register; the decode logic
//   then loads the result register from it. The block takes one
//   character per cycle while results are accepted; the result register
//   decouples the two sides.
//   When the receiver stalls, the result register holds, the decode stage
//   waits, and s_ready drops once the input register is also full.
//   Reset clears the string state, sets output_capacity to 4096 and
//   expected_bytes to 0, and empties both registers.

module base32_crockford_decoder_top #(
    parameter int unsigned MAX_INPUT = b32cd_pkg::MAX_INPUT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Character input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_char,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_final,
    output logic [7:0]  m_data_byte,
    output logic [2:0]  m_status,
    output logic [11:0] m_bytes_out,
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    // Counter widths follow from the scan limit
    localparam int unsigned SW       = $clog2(MAX_INPUT + 1);
    localparam int unsigned BYTE_MAX = (MAX_INPUT * 5) / 8;
    localparam int unsigned BW       = $clog2(BYTE_MAX + 1);
    localparam int unsigned OW       = (BW > 12) ? BW : 12;
    localparam int unsigned CW       = (BW > 13) ? BW : 13;
    localparam int unsigned VW       = ((SW + 3) > 17) ? (SW + 3) : 17;

    // Configuration registers
    logic [12:0] capacity_reg;
    logic [12:0] expected_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= b32cd_pkg::CAPACITY_RESET;
            expected_reg <= b32cd_pkg::EXPECTED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                b32cd_pkg::REG_OUTPUT_CAPACITY: capacity_reg <= cfg_data;
                b32cd_pkg::REG_EXPECTED_BYTES:  expected_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: terminator flag and character class
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             term_reg;
    b32cd_pkg::cls_t  cls_reg;
    logic             advance;
    logic             fire;
    logic             s_take;

    assign advance = !m_valid || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            term_reg <= (s_text_char == b32cd_pkg::CHAR_NUL);
            cls_reg  <= b32cd_pkg::classify(s_text_char);
        end
    end

    // String state
    logic [11:0] buf_reg,   buf_next;
    logic [2:0]  bcnt_reg,  bcnt_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [SW-1:0] vcnt_reg, vcnt_next;
    logic [BW-1:0] byte_reg, byte_next;
    logic [2:0]  err_reg,   err_next;

    // Result register
    logic        m_valid_reg,   m_valid_next;
    logic        final_reg,     final_next;
    logic [7:0]  data_reg,      data_next;
    logic [2:0]  status_reg,    status_next;
    logic [11:0] bytes_reg,     bytes_next;

    // Decode helpers
    logic [3:0]    bsum;
    logic [2:0]    bleft;
    logic [11:0]   buf_shift;
    logic [11:0]   pad_mask;
    logic [VW-1:0] v5;
    logic [VW-1:0] e8;
    logic          vcnt_ok;
    logic [CW-1:0] byte_cw;
    logic [CW-1:0] cap_cw;
    logic [CW-1:0] exp_cw;
    logic [OW-1:0] byte_ow;
    logic [OW-1:0] byte_inc_ow;
    logic          cap_bad;

    assign buf_shift = {buf_reg[6:0], cls_reg.value};
    assign bsum      = {1'b0, bcnt_reg} + 4'd5;
    assign bleft     = 3'(bsum - 4'd8);
    assign pad_mask  = ~(12'hFFF << bcnt_reg);
    // 8E <= 5V < 8E + 5 is the same as V == ceil(8E / 5)
    assign v5        = (VW'(vcnt_reg) << 2) + VW'(vcnt_reg);
    assign e8        = VW'(expected_reg) << 3;
    assign vcnt_ok   = (v5 >= e8) && (v5 < (e8 + VW'(5)));
    assign byte_cw   = CW'(byte_reg);
    assign cap_cw    = CW'(capacity_reg);
    assign exp_cw    = CW'(expected_reg);
    assign byte_ow   = OW'(byte_reg);
    assign byte_inc_ow = OW'(byte_reg) + OW'(1);
    assign cap_bad   = (expected_reg != 13'd0) && (capacity_reg < expected_reg);

    // Decode step for one character
    always_comb begin
        logic [2:0] err;
        buf_next     = buf_reg;
        bcnt_next    = bcnt_reg;
        scan_next    = scan_reg;
        vcnt_next    = vcnt_reg;
        byte_next    = byte_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        final_next   = final_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        bytes_next   = bytes_reg;
        err          = err_reg;

        if (advance) begin
            m_valid_next = 1'b0;
        end

        if (fire) begin
            if ((err == b32cd_pkg::ST_OK) && cap_bad) begin
                err = b32cd_pkg::ST_CAP_BELOW_EXP;
            end
            err_next = err;

            if (term_reg) begin
                // End of string: final checks, status transfer, clear state
                if ((err == b32cd_pkg::ST_OK) && (bcnt_reg != 3'd0) &&
                    ((buf_reg & pad_mask) != 12'd0)) begin
                    err = b32cd_pkg::ST_NONZERO_PAD;
                end
                if ((err == b32cd_pkg::ST_OK) && (expected_reg != 13'd0)) begin
                    if (!vcnt_ok) begin
                        err = b32cd_pkg::ST_CHAR_COUNT;
                    end else if (byte_cw != exp_cw) begin
                        err = b32cd_pkg::ST_BYTE_COUNT;
                    end
                end
                m_valid_next = 1'b1;
                final_next   = 1'b1;
                data_next    = 8'd0;
                status_next  = err;
                bytes_next   = byte_ow[11:0];
                buf_next     = 12'd0;
                bcnt_next    = 3'd0;
                scan_next    = '0;
                vcnt_next    = '0;
                byte_next    = '0;
                err_next     = b32cd_pkg::ST_OK;
            end else if (err != b32cd_pkg::ST_OK) begin
                // sticky error: character ignored
            end else if (scan_reg >= SW'(MAX_INPUT)) begin
                err_next = b32cd_pkg::ST_TOO_LONG;
            end else begin
                scan_next = scan_reg + SW'(1);
                if (cls_reg.skip) begin
                    // whitespace or dash
                end else if (cls_reg.bad) begin
                    err_next = b32cd_pkg::ST_BAD_CHAR;
                end else begin
                    buf_next  = buf_shift;
                    vcnt_next = vcnt_reg + SW'(1);
                    if (bsum >= 4'd8) begin
                        bcnt_next = bleft;
                        if (byte_cw >= cap_cw) begin
                            err_next = b32cd_pkg::ST_OUTPUT_FULL;
                        end else begin
                            byte_next    = byte_reg + BW'(1);
                            m_valid_next = 1'b1;
                            final_next   = 1'b0;
                            data_next    = 8'(buf_shift >> bleft);
                            status_next  = b32cd_pkg::ST_OK;
                            bytes_next   = byte_inc_ow[11:0];
                        end
                    end else begin
                        bcnt_next = bsum[2:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= 12'd0;
            bcnt_reg    <= 3'd0;
            scan_reg    <= '0;
            vcnt_reg    <= '0;
            byte_reg    <= '0;
            err_reg     <= b32cd_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            bcnt_reg    <= bcnt_next;
            scan_reg    <= scan_next;
            vcnt_reg    <= vcnt_next;
            byte_reg    <= byte_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        final_reg  <= final_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        bytes_reg  <= bytes_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_is_final  = final_reg;
    assign m_data_byte = data_reg;
    assign m_status    = status_reg;
    assign m_bytes_out = bytes_reg;

endmodule
